@@ rtl/mpt_pkg.sv @@
// ----------------------------------------------------------------------------
// mpt_pkg
// types and constants shared by the member presence table
// ----------------------------------------------------------------------------
package mpt_pkg;

	localparam int unsigned TABLE_ENTRIES_DEF = 32;

	localparam int unsigned MIX_W     = 32;
	localparam int unsigned MIX_SHIFT = 16;
	localparam logic [MIX_W-1:0] MIX_MULT = 32'h045d9f3b;

	// presence codes
	localparam logic [1:0] STATUS_ONLINE      = 2'd0;
	localparam logic [1:0] STATUS_OFFLINE     = 2'd1;
	localparam logic [1:0] STATUS_UNAVAILABLE = 2'd2;
	localparam logic [1:0] STATUS_UNUSED      = 2'd3;

	typedef struct packed {
		logic [31:0] member_id;
		logic [1:0]  status_code;
		logic [31:0] now_time;
		logic [31:0] client_last_sync;
	} upd_t;

	typedef struct packed {
		logic updated;
		logic table_full;
	} res_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] key;
		logic [1:0]  status;
		logic [31:0] stamp;
	} entry_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MIX_A,
		ST_MIX_B,
		ST_MIX_C,
		ST_MOD,
		ST_MOD_FIX,
		ST_PROBE_RD,
		ST_PROBE_CHK,
		ST_FINISH
	} state_t;

endpackage

@@ rtl/member_presence_table.sv @@
// ----------------------------------------------------------------------------
// member_presence_table
// presence table keyed by member id: hash, linear probe, insert or update
// ----------------------------------------------------------------------------
// sequence: the hash states ST_MIX_A, ST_MIX_B and ST_MIX_C, then ST_MOD and
//   ST_MOD_FIX when the table size is not a power of two, then ST_PROBE_RD and
//   ST_PROBE_CHK for each slot probed, then ST_FINISH, which waits on res_stall
//   to load the output register; one update at a time, a new one is taken in idle
// reset: a clearing pass over every entry wipes the valid marks, no
//   update is taken until it has finished
// ----------------------------------------------------------------------------
module member_presence_table
	import mpt_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,

	input  logic upd_valid,
	output logic upd_stall,
	input  upd_t upd,

	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
	localparam bit IS_POW2 = (TABLE_ENTRIES == (1 << IDX_W));
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic [IDX_W:0]   N_EXT    = (IDX_W + 1)'(TABLE_ENTRIES);
	// floor(2^32 / table size), for the remainder estimate
	localparam logic [MIX_W-1:0] RECIP    = MIX_W'((64'd1 << MIX_W) / TABLE_ENTRIES);

	// sequencer
	state_t state_q, state_d;

	// item held for the whole update
	logic [31:0] key_q;
	logic [1:0]  status_q;
	logic [31:0] now_q;
	logic [31:0] sync_q;

	// hash and slot search
	logic [MIX_W-1:0] mix_q;
	logic [IDX_W:0]   quot_q;
	logic [IDX_W-1:0] slot_q;
	logic [IDX_W-1:0] probe_cnt_q;
	logic [IDX_W-1:0] clr_q;

	// outcome of the probe, waiting for the output register
	logic fin_upd_q;
	logic fin_full_q;
	res_t res_q;
	logic res_valid_q;

	// entry store
	entry_t mem_q [TABLE_ENTRIES];
	entry_t rd_q;
	logic             mem_we;
	logic [IDX_W-1:0] mem_addr;
	entry_t           mem_wdata;

	// shared unit: xor-shift then multiply by the mix constant, or the hash
	// times the reciprocal of the table size
	logic [MIX_W-1:0]   xs;
	logic [MIX_W-1:0]   mul_a;
	logic [MIX_W-1:0]   mul_b;
	logic [2*MIX_W-1:0] prod_full;
	logic [MIX_W-1:0]   prod;

	// remainder from the reciprocal estimate, only used for table sizes that
	// are not powers of two; the estimate exceeds the remainder by at most one table size
	logic [IDX_W:0]   rem_est;
	logic [IDX_W:0]   rem_sub;
	logic             rem_ge;
	logic [IDX_W-1:0] rem_next;

	logic accept;
	logic hit;
	logic status_diff;
	logic newer;
	logic probe_last;
	logic res_load;

	assign xs        = (mix_q >> MIX_SHIFT) ^ mix_q;
	assign mul_a     = (state_q == ST_MOD) ? mix_q : xs;
	assign mul_b     = (state_q == ST_MOD) ? RECIP : MIX_MULT;
	assign prod_full = {{MIX_W{1'b0}}, mul_a} * {{MIX_W{1'b0}}, mul_b};
	assign prod      = prod_full[MIX_W-1:0];

	assign rem_est  = mix_q[IDX_W:0] - quot_q * N_EXT;
	assign rem_sub  = rem_est - N_EXT;
	assign rem_ge   = (rem_est >= N_EXT);
	assign rem_next = rem_ge ? rem_sub[IDX_W-1:0] : rem_est[IDX_W-1:0];

	assign hit         = rd_q.valid && (rd_q.key == key_q);
	assign status_diff = (rd_q.status != status_q);
	assign newer       = (rd_q.stamp > sync_q);
	assign probe_last  = (probe_cnt_q == LAST_IDX);

	assign upd_stall = (state_q != ST_IDLE);
	assign accept    = upd_valid && !upd_stall;
	assign res_load  = (state_q == ST_FINISH) && (!res_valid_q || !res_stall);

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and store write control
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_addr  = slot_q;
		mem_wdata = '{valid: 1'b1, key: key_q, status: status_q, stamp: now_q};
		case (state_q)
			ST_CLEAR: begin
				// sweep the store once, dropping every valid mark
				mem_we          = 1'b1;
				mem_addr        = clr_q;
				mem_wdata.valid = 1'b0;
				if (clr_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_MIX_A;
				end
			end
			ST_MIX_A: state_d = ST_MIX_B;
			ST_MIX_B: state_d = ST_MIX_C;
			ST_MIX_C: begin
				if (IS_POW2) begin
					state_d = ST_PROBE_RD;
				end else begin
					state_d = ST_MOD;
				end
			end
			ST_MOD: state_d = ST_MOD_FIX;
			ST_MOD_FIX: state_d = ST_PROBE_RD;
			ST_PROBE_RD: state_d = ST_PROBE_CHK;
			ST_PROBE_CHK: begin
				if (!rd_q.valid) begin
					// empty slot: insert the new member here
					mem_we  = 1'b1;
					state_d = ST_FINISH;
				end else if (hit) begin
					// known member, rewrite only on a change of status
					mem_we  = status_diff;
					state_d = ST_FINISH;
				end else if (probe_last) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_PROBE_RD;
				end
			end
			ST_FINISH: begin
				if (res_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					key_q    <= upd.member_id;
					status_q <= (upd.status_code == STATUS_UNUSED) ? STATUS_OFFLINE
						: upd.status_code;
					now_q    <= upd.now_time;
					sync_q   <= upd.client_last_sync;
					mix_q    <= upd.member_id;
				end
			end
			ST_MIX_A, ST_MIX_B: begin
				mix_q <= prod;
			end
			ST_MIX_C: begin
				mix_q       <= xs;
				slot_q      <= xs[IDX_W-1:0];
				probe_cnt_q <= '0;
			end
			ST_MOD: begin
				// low bits of the quotient estimate are all the remainder needs
				quot_q <= prod_full[MIX_W +: IDX_W + 1];
			end
			ST_MOD_FIX: begin
				slot_q <= rem_next;
			end
			ST_PROBE_CHK: begin
				if (!rd_q.valid) begin
					fin_upd_q  <= 1'b1;
					fin_full_q <= 1'b0;
				end else if (hit) begin
					fin_upd_q  <= status_diff || newer;
					fin_full_q <= 1'b0;
				end else if (probe_last) begin
					fin_upd_q  <= 1'b0;
					fin_full_q <= 1'b1;
				end else begin
					probe_cnt_q <= probe_cnt_q + 1'b1;
					slot_q      <= (slot_q == LAST_IDX) ? '0 : slot_q + 1'b1;
				end
			end
			ST_FINISH: begin
				if (res_load) begin
					res_q <= '{updated: fin_upd_q, table_full: fin_full_q};
				end
			end
			default: ;
		endcase
	end

	// entry store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_addr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem_q[slot_q];
	end

	// a result only appears after the sequencer has finished an update
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(state_q) == ST_FINISH)
		else $error("result raised without a finished update");

	// a full table never reports an update
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.updated && res.table_full))
		else $error("updated and table_full both set");

	// the store is written only by the clearing pass or the probe check
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_CLEAR || state_q == ST_PROBE_CHK))
		else $error("store written outside clearing or probe check");

endmodule
